### hw/rtl/assert_macros.svh
// assertion macros used by the top rtl file of the decoder
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property does not hold");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

### hw/rtl/b64sd_pkg.sv
// shared types and constants of the strict base64 decoder
// no dependencies
`timescale 1ns / 1ps

package b64sd_pkg;

   localparam int B64SD_QUEUE_DEPTH = 4;

   // status codes, lowest applicable code wins
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SYM   = 3'd1;
   localparam logic [2:0] ST_EARLY_PAD = 3'd2;
   localparam logic [2:0] ST_PAD_ORDER = 3'd3;
   localparam logic [2:0] ST_PAD_BITS  = 3'd4;
   localparam logic [2:0] ST_ZERO_BYTE = 3'd5;

   // one classified group, queued between front and back
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] byte_count;
      logic [2:0] status;
      logic       last_group;
   } entry_type;

   // one result as delivered
   typedef struct packed {
      entry_type  entry;
      logic       message_failed;
   } result_type;

endpackage

### hw/rtl/b64sd_front.sv
// front part: accepts groups, decodes symbols and classifies each group
// depends on b64sd_pkg
`timescale 1ns / 1ps

module b64sd_front
   import b64sd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   input  logic        q_ready,
   output logic        q_push,
   output entry_type   q_entry
);

   localparam logic [7:0] CH_PAD     = 8'h3D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] LOWER_OFS  = CH_LOWER_A - 8'd26;
   localparam logic [7:0] DIGIT_OFS  = 8'd52 - CH_DIGIT_0;
   localparam logic [6:0] SYM_BAD    = 7'h40;

   // bit 6 flags a character outside the alphabet
   function automatic logic [6:0] sym_value(input logic [7:0] ch);
      logic [7:0] diff;
      logic [6:0] val;
      diff = 8'd0;
      val  = SYM_BAD;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
         diff = ch - CH_UPPER_A;
         val  = {1'b0, diff[5:0]};
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
         diff = ch - LOWER_OFS;
         val  = {1'b0, diff[5:0]};
      end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
         diff = ch + DIGIT_OFS;
         val  = {1'b0, diff[5:0]};
      end else if (ch == CH_PLUS) begin
         val = 7'd62;
      end else if (ch == CH_SLASH) begin
         val = 7'd63;
      end
      return val;
   endfunction

   logic        reject_zero_ff;
   logic        reject_zero_in;
   logic [7:0]  s0, s1, s2, s3;
   logic        p2, p3;
   logic [6:0]  va, vb, vc, vd;
   logic [23:0] triple;
   logic [7:0]  b0, b1, b2;
   logic        in1, in2;
   logic        bad, zero_hit;
   logic [2:0]  status;

   assign csr_ready = 1'b1;
   assign req_tready = q_ready;
   assign q_push = req_tvalid & q_ready;

   always_comb begin
      reject_zero_in = reject_zero_ff;
      if (csr_valid) begin
         reject_zero_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reject_zero_ff <= 1'b1;
      end else begin
         reject_zero_ff <= reject_zero_in;
      end
   end

   always_comb begin
      s0 = req_tdata[7:0];
      s1 = req_tdata[15:8];
      s2 = req_tdata[23:16];
      s3 = req_tdata[31:24];
      p2 = (s2 == CH_PAD);
      p3 = (s3 == CH_PAD);
      va = sym_value(s0);
      vb = sym_value(s1);
      vc = p2 ? 7'd0 : sym_value(s2);
      vd = p3 ? 7'd0 : sym_value(s3);
      bad = va[6] | vb[6] | vc[6] | vd[6];
      triple = {va[5:0], vb[5:0], vc[5:0], vd[5:0]};
      // byte1 lives unless both places pad, byte2 only without padding
      in1 = !(p2 && p3);
      in2 = !p2 && !p3;
      b0 = triple[23:16];
      b1 = in1 ? triple[15:8] : 8'd0;
      b2 = in2 ? triple[7:0] : 8'd0;
      zero_hit = reject_zero_ff &&
                 ((b0 == 8'd0) || (in1 && b1 == 8'd0) || (in2 && b2 == 8'd0));

      if (bad) begin
         status = ST_BAD_SYM;
      end else if (!req_tlast && (p2 || p3)) begin
         status = ST_EARLY_PAD;
      end else if (p2 && !p3) begin
         status = ST_PAD_ORDER;
      end else if ((p2 && vb[3:0] != 4'd0) || (p3 && !p2 && vc[1:0] != 2'd0)) begin
         status = ST_PAD_BITS;
      end else if (zero_hit) begin
         status = ST_ZERO_BYTE;
      end else begin
         status = ST_OK;
      end

      q_entry.byte0      = (status == ST_OK) ? b0 : 8'd0;
      q_entry.byte1      = (status == ST_OK) ? b1 : 8'd0;
      q_entry.byte2      = (status == ST_OK) ? b2 : 8'd0;
      q_entry.byte_count = (p2 && p3) ? 2'd1 : ((p2 || p3) ? 2'd2 : 2'd3);
      q_entry.status     = status;
      q_entry.last_group = req_tlast;
   end

endmodule

### hw/rtl/b64sd_queue.sv
// short queue of classified groups between front and back
// depends on b64sd_pkg
`timescale 1ns / 1ps

module b64sd_queue
   import b64sd_pkg::*;
#(
   parameter int DEPTH = B64SD_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      push_ready,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/b64sd_back.sv
// back part: tracks message failure and drives the result register
// depends on b64sd_pkg
`timescale 1ns / 1ps

module b64sd_back
   import b64sd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  q_entry,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;
   logic       sticky_ff, sticky_in;
   logic       failed;

   assign q_pop      = q_valid & (!valid_ff | out_ready);
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      failed    = sticky_ff | (q_entry.status != ST_OK);
      valid_in  = valid_ff;
      sticky_in = sticky_ff;
      result_in = result_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (q_pop) begin
         valid_in                 = 1'b1;
         result_in.entry          = q_entry;
         result_in.message_failed = failed;
         // last item of a message starts the next one clean
         sticky_in = q_entry.last_group ? 1'b0 : failed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         sticky_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         sticky_ff <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

### hw/rtl/base64_strict_decoder.sv
// strict base64 decoder, one four-character group per item
// path: req acceptance writes the queue, then the result register drives rsp_tvalid
// throughput: one item per cycle while the queue is not full; the queue of QUEUE_DEPTH entries absorbs rsp stalls
// reset: synchronous, clears queue, result valid and failure flag; reject_zero_byte to 1
// depends on b64sd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module base64_strict_decoder
   import b64sd_pkg::*;
#(
   parameter int QUEUE_DEPTH = B64SD_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // sym0, sym1, sym2, sym3
   input  logic        req_tlast,  // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // byte0, byte1, byte2, byte_count, status, zero fill
   output logic        rsp_tuser,  // message_failed
   output logic        rsp_tlast,  // last_group
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data    // reject_zero_byte
);

   entry_type  push_entry, pop_entry;
   logic       push, push_ready, pop, pop_valid;
   result_type result;

   b64sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_ready    (push_ready),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   b64sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   b64sd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_entry    (pop_entry),
      .q_pop      (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {3'd0, result.entry.status, result.entry.byte_count,
                       result.entry.byte2, result.entry.byte1, result.entry.byte0};
   assign rsp_tuser = result.message_failed;
   assign rsp_tlast = result.entry.last_group;

   `ASSERT_ALWAYS(a_fail_flags_message, clock, reset,
      !rsp_tvalid || result.entry.status == ST_OK || result.message_failed)
   `ASSERT_ALWAYS(a_fail_clears_bytes, clock, reset,
      !rsp_tvalid || result.entry.status == ST_OK ||
      (result.entry.byte0 == 8'd0 && result.entry.byte1 == 8'd0 &&
       result.entry.byte2 == 8'd0))
   `ASSERT_ALWAYS(a_count_nonzero, clock, reset,
      !rsp_tvalid || result.entry.byte_count != 2'd0)
   `ASSERT_NEXT(a_push_lands_in_queue, clock, reset, push, pop_valid)

endmodule
